>>> rtl/ccs_pkg.sv
// Charging contact sequencer: shared types and constants.
// No dependencies; imported by the interfaces and all modules.
package ccs_pkg;

  localparam int unsigned CfgRegs   = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_EXTEND_WAIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_REPLY_TIMEOUT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_RETRACT_WAIT  = 2'd3;

  localparam logic [15:0] THRESHOLD_RST     = 16'd60000;
  localparam logic [15:0] EXTEND_WAIT_RST   = 16'd2000;
  localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] RETRACT_WAIT_RST  = 16'd2000;

  // error codes
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_BAD_BEFORE   = 2'd1;
  localparam logic [1:0] ERR_BAD_AFTER    = 2'd2;
  localparam logic [1:0] ERR_REPLY        = 2'd3;

  typedef struct packed {
    logic        switch_pressed;
    logic [15:0] contact_level;
    logic        reply_valid;
    logic        reply_ok;
  } ccs_in_t;

  typedef struct packed {
    logic       led_on;
    logic       actuator_out;
    logic       contact_closed;
    logic       send_extended;
    logic       send_done;
    logic [1:0] error_code;
  } ccs_out_t;

  typedef struct packed {
    logic [15:0] contact_threshold;
    logic [15:0] extend_wait_ms;
    logic [15:0] reply_timeout_ms;
    logic [15:0] retract_wait_ms;
  } ccs_cfg_t;

endpackage

>>> rtl/ccs_if.sv
// Valid/ready channel interfaces for the sequencer's tick input and result output.
// Depends on ccs_pkg for the payload structs.
interface ccs_in_if;
  import ccs_pkg::*;
  logic    valid;
  logic    ready;
  ccs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccs_out_if;
  import ccs_pkg::*;
  logic     valid;
  logic     ready;
  ccs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ccs_cfg_regs.sv
// Configuration register bank for the sequencer (threshold and wait times).
// Depends on ccs_pkg.
module ccs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [ccs_pkg::CfgIdxW-1:0]       index,
  input  logic [ccs_pkg::CfgDataW-1:0]      wdata,
  output ccs_pkg::ccs_cfg_t                 cfg
);
  import ccs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contact_threshold <= THRESHOLD_RST;
      cfg.extend_wait_ms    <= EXTEND_WAIT_RST;
      cfg.reply_timeout_ms  <= REPLY_TIMEOUT_RST;
      cfg.retract_wait_ms   <= RETRACT_WAIT_RST;
    end else if (wr_en) begin
      unique case (index)
        REG_THRESHOLD:     cfg.contact_threshold <= wdata;
        REG_EXTEND_WAIT:   cfg.extend_wait_ms    <= wdata;
        REG_REPLY_TIMEOUT: cfg.reply_timeout_ms  <= wdata;
        REG_RETRACT_WAIT:  cfg.retract_wait_ms   <= wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ccs_step.sv
// Sequencer state machine: phase, tick counter and relay/led state, advanced
// once per accepted tick. Depends on ccs_pkg.
module ccs_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  ccs_pkg::ccs_in_t   item,
  input  ccs_pkg::ccs_cfg_t  cfg,
  output ccs_pkg::ccs_out_t  res_next
);
  import ccs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_EXTEND  = 3'd1,
    PH_REPLY   = 3'd2,
    PH_CHARGE  = 3'd3,
    PH_RETRACT = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic        actuator_reg, actuator_reg_next;
  logic        contact_reg, contact_reg_next;
  logic        led_reg, led_reg_next;
  logic [15:0] tick_inc;
  logic        level_good;
  logic        send_ext, send_dn;
  logic [1:0]  err;

  assign tick_inc   = tick_count + 16'd1;
  assign level_good = item.contact_level > cfg.contact_threshold;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    actuator_reg_next = actuator_reg;
    contact_reg_next  = contact_reg;
    led_reg_next      = led_reg;
    send_ext          = 1'b0;
    send_dn           = 1'b0;
    err               = ERR_NONE;
    unique case (phase)
      PH_EXTEND: begin
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.extend_wait_ms) begin
          if (level_good) begin
            send_ext        = 1'b1;
            tick_count_next = '0;
            phase_next      = PH_REPLY;
          end else begin
            err          = ERR_BAD_AFTER;
            led_reg_next = 1'b0;
            phase_next   = PH_IDLE;
          end
        end
      end
      PH_REPLY: begin
        if (item.reply_valid) begin
          if (item.reply_ok) begin
            contact_reg_next = 1'b1;
            phase_next       = PH_CHARGE;
          end else begin
            err          = ERR_REPLY;
            led_reg_next = 1'b0;
            phase_next   = PH_IDLE;
          end
        end else begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.reply_timeout_ms) begin
            err          = ERR_REPLY;
            led_reg_next = 1'b0;
            phase_next   = PH_IDLE;
          end
        end
      end
      PH_CHARGE: begin
        if (item.switch_pressed) begin
          send_dn           = 1'b1;
          actuator_reg_next = 1'b0;
          tick_count_next   = '0;
          phase_next        = PH_RETRACT;
        end
      end
      PH_RETRACT: begin
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.retract_wait_ms) begin
          contact_reg_next = 1'b0;
          led_reg_next     = 1'b0;
          phase_next       = PH_IDLE;
        end
      end
      default: begin
        // idle, and any stray code
        phase_next = PH_IDLE;
        if (item.switch_pressed) begin
          if (level_good) begin
            led_reg_next      = 1'b1;
            actuator_reg_next = 1'b1;
            tick_count_next   = '0;
            phase_next        = PH_EXTEND;
          end else begin
            led_reg_next = 1'b0;
            err          = ERR_BAD_BEFORE;
          end
        end
      end
    endcase

    res_next.led_on         = led_reg_next;
    res_next.actuator_out   = actuator_reg_next;
    res_next.contact_closed = contact_reg_next;
    res_next.send_extended  = send_ext;
    res_next.send_done      = send_dn;
    res_next.error_code     = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      actuator_reg <= 1'b0;
      contact_reg  <= 1'b0;
      led_reg      <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      actuator_reg <= actuator_reg_next;
      contact_reg  <= contact_reg_next;
      led_reg      <= led_reg_next;
    end
  end

endmodule

>>> rtl/charging_contact_sequencer_unit.sv
// Top level of the charging contact sequencer: handshake, result register,
// config bank and state machine. Depends on ccs_pkg, ccs_if, ccs_cfg_regs, ccs_step.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+------------------------------------------
//   item     | in  | valid / ready  | switch_pressed, contact_level, reply_*
//   result   | out | valid / ready  | led_on, actuator_out, contact_closed,
//            |     |                | send_extended, send_done, error_code
//   cfg      | in  | cfg_wr_en      | cfg_index, cfg_wdata (no read-back)
//
// One tick per clock unless the result stalls: each accepted item updates the
// state and loads the result register in the same cycle.
// item.ready is high while the result register is empty or being drained,
// so a stalled result holds off only the next item.
// Synchronous reset returns to idle with relays and led off, registers at defaults.
module charging_contact_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst,
  ccs_in_if.sink                        item,
  ccs_out_if.source                     result,
  input  logic                          cfg_wr_en,
  input  logic [ccs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ccs_pkg::CfgDataW-1:0]  cfg_wdata
);
  import ccs_pkg::*;

  ccs_cfg_t cfg;
  ccs_out_t res_next;
  ccs_out_t res_data;
  logic     res_valid;
  logic     accept;

  assign item.ready  = !res_valid || result.ready;
  assign accept      = item.valid && item.ready;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  ccs_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  ccs_step u_step (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .item     (item.data),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_next;
    end
  end

endmodule

>>> rtl/ccs_checker.sv
// Port-level assertions for the charging contact sequencer, bound to the top.
// Depends on ccs_pkg and charging_contact_sequencer_unit.
module ccs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ccs_pkg::ccs_out_t  out_data
);
  import ccs_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every transaction in yields a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // any failure drops the busy led and sends nothing
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_code != ERR_NONE |->
      !out_data.led_on && !out_data.send_extended && !out_data.send_done)
    else $error("error result with led or message");

  a_ext: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.send_extended |->
      out_data.led_on && out_data.actuator_out && !out_data.contact_closed)
    else $error("extended message outside extended state");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.send_done |->
      !out_data.actuator_out && out_data.contact_closed && out_data.led_on)
    else $error("done message without retract");

endmodule

bind charging_contact_sequencer_unit ccs_checker u_ccs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
